[rtl/assert_macros.svh]
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication under active-low reset.
`define AST_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// Next-cycle implication under active-low reset.
`define AST_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define AST_IMPLY(lbl, clk, rst_n, a, b)
`define AST_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

[rtl/aes_pkg.sv]
// AES constants, S-boxes and round functions.
package aes_pkg;

	localparam int NUM_STAGES = 14;
	localparam int NUM_WORDS  = 60;
	localparam int KEY_REGS   = 5;

	localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
	localparam logic [2:0] REG_KEY_WORD_0 = 3'd1;
	localparam logic [2:0] REG_KEY_WORD_1 = 3'd2;
	localparam logic [2:0] REG_KEY_WORD_2 = 3'd3;
	localparam logic [2:0] REG_KEY_WORD_3 = 3'd4;

	localparam logic [1:0] KLEN_128 = 2'd0;
	localparam logic [1:0] KLEN_192 = 2'd1;

	localparam logic [7:0] RC_INIT = 8'h01;

	localparam logic [7:0] SBOX [0:255] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [7:0] INV_SBOX [0:255] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// Rounds for a key length code; code 3 runs as 256-bit.
	function automatic logic [3:0] rounds(input logic [1:0] klen);
		case (klen)
			KLEN_128: return 4'd10;
			KLEN_192: return 4'd12;
			default:  return 4'd14;
		endcase
	endfunction

	function automatic logic [3:0] key_words(input logic [1:0] klen);
		case (klen)
			KLEN_128: return 4'd4;
			KLEN_192: return 4'd6;
			default:  return 4'd8;
		endcase
	endfunction

	// One round; state byte i sits at bits [127-8i -: 8].
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
		input logic dec, input logic last);
		logic [7:0] b [16];
		logic [7:0] h [16];
		logic [7:0] m [16];
		logic [7:0] t0, t1, t2, t3;
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [127:0] sh, a, mx;
		for (int i = 0; i < 16; i++) begin
			b[i] = dec ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (dec)
					h[((c + r) % 4) * 4 + r] = b[c * 4 + r];
				else
					h[c * 4 + r] = b[((c + r) % 4) * 4 + r];
			end
		end
		for (int i = 0; i < 16; i++) sh[127-8*i -: 8] = h[i];
		a = dec ? (sh ^ k) : sh;
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				x2[j] = xtime(a[127-8*(c*4+j) -: 8]);
				x4[j] = xtime(x2[j]);
				x8[j] = xtime(x4[j]);
			end
			for (int r = 0; r < 4; r++) begin
				t0 = a[127-8*(c*4+r) -: 8];
				t1 = a[127-8*(c*4+(r+1)%4) -: 8];
				t2 = a[127-8*(c*4+(r+2)%4) -: 8];
				t3 = a[127-8*(c*4+(r+3)%4) -: 8];
				if (dec)
					m[c*4+r] = (x8[r] ^ x4[r] ^ x2[r])
						^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ t1)
						^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ t2)
						^ (x8[(r+3)%4] ^ t3);
				else
					m[c*4+r] = x2[r] ^ (x2[(r+1)%4] ^ t1) ^ t2 ^ t3 ^ (t0 & 8'h00);
			end
		end
		for (int i = 0; i < 16; i++) mx[127-8*i -: 8] = m[i];
		if (dec) return last ? a : mx;
		return (last ? sh : mx) ^ k;
	endfunction

endpackage

[rtl/aes_block_cipher_core.sv]
// AES block cipher, 128/192/256-bit keys, one round per pipeline stage.
//
// Configuration: cfg_we/cfg_index/cfg_data write key_length (0) and the key
// words (1..4). Any write to these registers starts a key expansion that
// produces one schedule word per cycle, 44, 52 or 60 words for 128, 192 or
// 256-bit keys. The input is held off (s_tready low) while it runs.
// Input beats: s_tdata = {block_low, block_high}, s_tuser = operation
// (0 encrypt, 1 decrypt). Output beats: m_tdata = {result_low, result_high}.
// The pipeline has one stage for the first key add and fourteen round
// stages; with shorter keys the trailing stages pass the block through.
// With one round per stage, throughput is one block per cycle when unstalled
// and no key expansion runs. Each stage has its own valid bit and holds
// only when the stage after it is full and holding, so a stalled receiver
// fills bubbles before back-pressure reaches s_tready; nothing is dropped
// or repeated. Reset clears the key registers to zero, empties the pipeline
// and runs the expansion for the all-zero 128-bit key.
module aes_block_cipher_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // block_low, block_high
	input  logic         s_tuser,   // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata    // result_low, result_high
);
`include "assert_macros.svh"

	localparam int NS = aes_pkg::NUM_STAGES;

	logic [1:0]  klen_q;
	logic [63:0] kw_q [4];
	logic [31:0] rk_q [aes_pkg::NUM_WORDS];
	logic [31:0] win_q [8];
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [2:0]  mod_q;
	logic [7:0]  rc_q;

	logic [3:0]  nr, nk;
	logic [5:0]  total;
	logic [31:0] key_in, prev, tmp, new_word, old_word;
	logic        cfg_hit;

	assign nr    = aes_pkg::rounds(klen_q);
	assign nk    = aes_pkg::key_words(klen_q);
	assign total = {nr, 2'b00} + 6'd4;
	assign cfg_hit = cfg_we && (cfg_index <= aes_pkg::REG_KEY_WORD_3);

	always_comb begin
		unique case (cnt_q[2:0])
			3'd0: key_in = kw_q[0][63:32];
			3'd1: key_in = kw_q[0][31:0];
			3'd2: key_in = kw_q[1][63:32];
			3'd3: key_in = kw_q[1][31:0];
			3'd4: key_in = kw_q[2][63:32];
			3'd5: key_in = kw_q[2][31:0];
			3'd6: key_in = kw_q[3][63:32];
			default: key_in = kw_q[3][31:0];
		endcase
		case (klen_q)
			aes_pkg::KLEN_128: old_word = win_q[4];
			aes_pkg::KLEN_192: old_word = win_q[2];
			default:           old_word = win_q[0];
		endcase
		prev = win_q[7];
		if (mod_q == 3'd0)
			tmp = aes_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rc_q, 24'h0};
		else if (nk == 4'd8 && mod_q == 3'd4)
			tmp = aes_pkg::sub_word(prev);
		else
			tmp = prev;
		new_word = (cnt_q < {2'b00, nk}) ? key_in : (old_word ^ tmp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= '0;
			for (int i = 0; i < 4; i++) kw_q[i] <= '0;
			busy_q <= 1'b1;
			cnt_q  <= '0;
			mod_q  <= '0;
			rc_q   <= aes_pkg::RC_INIT;
		end else if (cfg_hit) begin
			unique case (cfg_index)
				aes_pkg::REG_KEY_LENGTH: klen_q <= cfg_data[1:0];
				aes_pkg::REG_KEY_WORD_0: kw_q[0] <= cfg_data;
				aes_pkg::REG_KEY_WORD_1: kw_q[1] <= cfg_data;
				aes_pkg::REG_KEY_WORD_2: kw_q[2] <= cfg_data;
				default:                 kw_q[3] <= cfg_data;
			endcase
			busy_q <= 1'b1;
			cnt_q  <= '0;
			mod_q  <= '0;
			rc_q   <= aes_pkg::RC_INIT;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			mod_q <= (mod_q == nk[2:0] - 3'd1) ? 3'd0 : mod_q + 3'd1;
			if (cnt_q >= {2'b00, nk} && mod_q == 3'd0) rc_q <= aes_pkg::xtime(rc_q);
			if (cnt_q == total - 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !cfg_hit) begin
			rk_q[cnt_q] <= new_word;
			for (int i = 0; i < 7; i++) win_q[i] <= win_q[i + 1];
			win_q[7] <= new_word;
		end
	end

	logic [127:0] rkey [NS + 1];
	for (genvar r = 0; r <= NS; r++) begin : g_rkey
		assign rkey[r] = {rk_q[4*r], rk_q[4*r+1], rk_q[4*r+2], rk_q[4*r+3]};
	end

	// Pipeline: stage 0 holds the first key add, stages 1..NS one round each or a pass-through.
	logic [127:0] data_s [NS + 1];
	logic         vld_s  [NS + 1];
	logic         op_s   [NS + 1];
	logic         rdy    [NS + 1];

	always_comb begin
		rdy[NS] = m_tready || !vld_s[NS];
		for (int k = NS - 1; k >= 0; k--) rdy[k] = !vld_s[k] || rdy[k + 1];
	end

	assign s_tready = rdy[0] && !busy_q;

	logic [127:0] key_last, in_state;
	always_comb begin
		case (klen_q)
			aes_pkg::KLEN_128: key_last = rkey[10];
			aes_pkg::KLEN_192: key_last = rkey[12];
			default:           key_last = rkey[14];
		endcase
	end
	assign in_state = {s_tdata[63:0], s_tdata[127:64]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (rdy[0]) vld_s[0] <= s_tvalid && !busy_q;
	end
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s[0] <= in_state ^ (s_tuser ? key_last : rkey[0]);
			op_s[0]   <= s_tuser;
		end
	end

	for (genvar k = 1; k <= NS; k++) begin : g_stage
		localparam int D10 = (k <= 10) ? 10 - k : 0;
		localparam int D12 = (k <= 12) ? 12 - k : 0;
		localparam int D14 = 14 - k;
		logic [127:0] key_k, nxt;
		always_comb begin
			if (!op_s[k-1])
				key_k = rkey[k];
			else if (nr == 4'd10)
				key_k = rkey[D10];
			else if (nr == 4'd12)
				key_k = rkey[D12];
			else
				key_k = rkey[D14];
			if (4'(k) > nr)
				nxt = data_s[k-1];
			else
				nxt = aes_pkg::aes_round(data_s[k-1], key_k, op_s[k-1], 4'(k) == nr);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (rdy[k]) vld_s[k] <= vld_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (rdy[k] && vld_s[k-1]) begin
				data_s[k] <= nxt;
				op_s[k]   <= op_s[k-1];
			end
		end
	end

	assign m_tvalid = vld_s[NS];
	assign m_tdata  = {data_s[NS][63:0], data_s[NS][127:64]};

	`AST_IMPLY(a_no_accept_busy, clk, arst_n, busy_q, !s_tready)
	`AST_NEXT(a_cfg_restarts, clk, arst_n, cfg_hit, busy_q && cnt_q == 6'd0)
	`AST_IMPLY(a_cnt_bound, clk, arst_n, busy_q, cnt_q < total)
	`AST_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

endmodule

[sim/aes_block_cipher_core_tb.sv]
// Self-checking AES block cipher core testbench: directed vectors, random keys, texts and handshake timing.
`timescale 1ns / 100ps

module aes_block_cipher_core_tb;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;   // block_low, block_high
	logic         s_tuser;   // operation
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // result_low, result_high

	aes_block_cipher_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Cipher model: copies of the key registers held in the testbench; schedule and state are computed from them.
	logic [1:0]  key_len_q;
	logic [63:0] key_q [4];

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic logic [127:0] aes_predict(input logic op, input logic [127:0] text);
		logic [31:0] w [60];
		logic [7:0]  st [16];
		logic [7:0]  o [16];
		logic [7:0]  cm [4];
		logic [7:0]  rc;
		logic [31:0] t;
		int nk, nr;
		logic [127:0] res;
		nk = (key_len_q == aes_pkg::KLEN_128) ? 4 : (key_len_q == aes_pkg::KLEN_192) ? 6 : 8;
		nr = nk + 6;
		for (int i = 0; i < 4; i++) begin
			w[2*i] = key_q[i][63:32];
			w[2*i+1] = key_q[i][31:0];
		end
		rc = 8'h01;
		for (int i = nk; i < 4 * (nr + 1); i++) begin
			t = w[i-1];
			if (i % nk == 0) begin
				t = {t[23:0], t[31:24]};
				t = {aes_pkg::SBOX[t[31:24]], aes_pkg::SBOX[t[23:16]],
					aes_pkg::SBOX[t[15:8]], aes_pkg::SBOX[t[7:0]]};
				t ^= {rc, 24'h0};
				rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
			end else if (nk == 8 && i % nk == 4) begin
				t = {aes_pkg::SBOX[t[31:24]], aes_pkg::SBOX[t[23:16]],
					aes_pkg::SBOX[t[15:8]], aes_pkg::SBOX[t[7:0]]};
			end
			w[i] = w[i-nk] ^ t;
		end
		for (int i = 0; i < 16; i++) st[i] = text[127-8*i -: 8];
		for (int k = 0; k <= nr; k++) begin
			int rnd;
			rnd = op ? nr - k : k;
			if (k > 0) begin
				// substitution and row shift
				o = st;
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						if (op) st[((c + r) % 4) * 4 + r] = aes_pkg::INV_SBOX[o[c*4+r]];
						else st[c*4+r] = aes_pkg::SBOX[o[((c + r) % 4) * 4 + r]];
				if (!op && k < nr) begin
					for (int c = 0; c < 4; c++) begin
						for (int r = 0; r < 4; r++) cm[r] = st[c*4+r];
						for (int r = 0; r < 4; r++)
							st[c*4+r] = gmul(cm[r], 8'd2) ^ gmul(cm[(r+1)%4], 8'd3)
								^ cm[(r+2)%4] ^ cm[(r+3)%4];
					end
				end
			end
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					st[c*4+r] ^= w[rnd*4+c][31-8*r -: 8];
			if (op && k > 0 && k < nr) begin
				for (int c = 0; c < 4; c++) begin
					for (int r = 0; r < 4; r++) cm[r] = st[c*4+r];
					for (int r = 0; r < 4; r++)
						st[c*4+r] = gmul(cm[r], 8'd14) ^ gmul(cm[(r+1)%4], 8'd11)
							^ gmul(cm[(r+2)%4], 8'd13) ^ gmul(cm[(r+3)%4], 8'd9);
				end
			end
		end
		for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
		return res;
	endfunction

	// Expected values are {result_high, result_low}; m_tdata carries result_high low.
	class cipher_scoreboard;
		logic [127:0] pending_q [$];
		int errors;

		function void note_block(input logic [127:0] res);
			pending_q.push_back(res);
		endfunction

		function void check_result(input logic [127:0] got);
			logic [127:0] exp;
			if (pending_q.size() == 0) begin
				$error("result with nothing pending: %h", got);
				errors++;
				return;
			end
			exp = pending_q.pop_front();
			if (got[63:0] !== exp[127:64]) begin
				$error("result_high expected %h actual %h", exp[127:64], got[63:0]);
				errors++;
			end
			if (got[127:64] !== exp[63:0]) begin
				$error("result_low expected %h actual %h", exp[63:0], got[127:64]);
				errors++;
			end
		endfunction
	endclass

	cipher_scoreboard sb;
	bit hold_rx;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Sparse, dense and random 64-bit values for extremes and bit coverage.
	function automatic logic [63:0] pick64();
		case ($urandom_range(0, 9))
			0: return 64'h0;
			1: return '1;
			2: return 64'h1 << $urandom_range(0, 63);
			default: return rand64();
		endcase
	endfunction

	// Write enable stays up across back-to-back writes; end_cfg drops it.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			aes_pkg::REG_KEY_LENGTH: key_len_q = val[1:0];
			aes_pkg::REG_KEY_WORD_0: key_q[0] = val;
			aes_pkg::REG_KEY_WORD_1: key_q[1] = val;
			aes_pkg::REG_KEY_WORD_2: key_q[2] = val;
			aes_pkg::REG_KEY_WORD_3: key_q[3] = val;
			default: ;
		endcase
	endtask

	task automatic end_cfg();
		cfg_we <= 1'b0;
	endtask

	task automatic send_block(input logic op, input logic [127:0] text, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {text[63:0], text[127:64]};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_block(aes_predict(op, text));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_key(input logic [1:0] klen, input logic [63:0] k0, input logic [63:0] k1,
		input logic [63:0] k2, input logic [63:0] k3);
		write_reg(aes_pkg::REG_KEY_LENGTH, {62'h0, klen});
		write_reg(aes_pkg::REG_KEY_WORD_0, k0);
		write_reg(aes_pkg::REG_KEY_WORD_1, k1);
		write_reg(aes_pkg::REG_KEY_WORD_2, k2);
		write_reg(aes_pkg::REG_KEY_WORD_3, k3);
	endtask

	// Receiver: random stalls and an optional long hold, sampled at the edge.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				m_tready <= 1'b0;
				repeat (150) @(posedge clk);
				hold_rx = 1'b0;
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			sb.check_result(m_tdata);
		end
	end

	initial begin
		logic [127:0] txt;
		logic [1:0] kl;
		sb = new();
		key_len_q = aes_pkg::KLEN_128;
		for (int i = 0; i < 4; i++) key_q[i] = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset key, then FIPS-197 appendix C vectors.
		send_block(OP_ENCRYPT, '0, 1'b0);
		send_block(OP_DECRYPT, '1, 1'b0);
		drain();
		set_key(aes_pkg::KLEN_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
		end_cfg();
		send_block(OP_ENCRYPT, 128'h00112233445566778899aabbccddeeff, 1'b0);
		send_block(OP_DECRYPT, 128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b0);
		drain();
		set_key(aes_pkg::KLEN_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, '1);
		end_cfg();
		send_block(OP_ENCRYPT, 128'h00112233445566778899aabbccddeeff, 1'b0);
		send_block(OP_DECRYPT, '0, 1'b0);
		drain();
		set_key(aes_pkg::KLEN_192 + 2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h18191a1b1c1d1e1f);
		end_cfg();
		send_block(OP_ENCRYPT, 128'h00112233445566778899aabbccddeeff, 1'b0);
		send_block(OP_DECRYPT, 128'h8ea2b7ca516745bfeafc49904b496089, 1'b0);
		drain();
		// unused size code runs as 256-bit; out-of-range index is ignored
		set_key(2'd3, '1, '1, '1, '1);
		write_reg(3'd5, rand64());
		write_reg(3'd7, rand64());
		end_cfg();
		send_block(OP_ENCRYPT, '1, 1'b0);
		send_block(OP_DECRYPT, '0, 1'b0);
		drain();

		// Random phases with varying keys; long receiver hold in one phase.
		for (int ph = 0; ph < 13; ph++) begin
			kl = (ph < 3) ? ph[1:0] : 2'($urandom_range(0, 3));
			set_key(kl, pick64(), pick64(), pick64(), pick64());
			end_cfg();
			if (ph == 5) hold_rx = 1'b1;
			for (int n = 0; n < 48; n++) begin
				txt = {pick64(), pick64()};
				send_block(1'($urandom_range(0, 1)), txt, (ph % 4) != 1);
			end
			drain();
		end
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
